@@ rtl/core/rct_pkg.sv @@
// Ratings table package: sizes, field widths, command and status codes,
// datapath micro-operations and the datapath status struct. No dependencies.
package rct_pkg;

	localparam int MAX_RATINGS = 4096;
	localparam int MAX_USERS   = 1024;
	localparam int MAX_ITEMS   = 1024;
	localparam int MAX_KEYS    = (MAX_USERS > MAX_ITEMS) ? MAX_USERS : MAX_ITEMS;

	localparam int RC_W   = $clog2(MAX_RATINGS + 1);
	localparam int RA_W   = $clog2(MAX_RATINGS);
	localparam int NK_W   = $clog2(MAX_KEYS + 1);
	localparam int KA_W   = $clog2(MAX_KEYS);
	localparam int RT_W   = 8;
	localparam int ID_W   = 32;
	localparam int CMD_W  = 4;
	localparam int ST_W   = 3;
	localparam int SLOT_W = 11;
	localparam int POS_W  = 12;
	localparam int EIDX_W = 10;
	localparam int CNT_W  = 13;
	localparam int TOT_W  = 11;
	localparam int SUM_W  = RA_W + RT_W;
	localparam int ENT_W  = KA_W + RT_W;
	localparam int RAW_W  = 2 * KA_W + RT_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 4'd0,
		CMD_LOAD   = 4'd1,
		CMD_BUILD  = 4'd2,
		CMD_ULOOK  = 4'd3,
		CMD_ILOOK  = 4'd4,
		CMD_UENTRY = 4'd5,
		CMD_IENTRY = 4'd6,
		CMD_UMEAN  = 4'd7,
		CMD_IMEAN  = 4'd8,
		CMD_GMEAN  = 4'd9
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_RANGE     = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_BUILT = 3'd4,
		ST_BUILT     = 3'd5
	} status_t;

	typedef enum logic [5:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_SRCH_RD,
		OP_SRCH_CMP,
		OP_SAVE_U,
		OP_FIN_PRE,
		OP_FIN_CLEAR,
		OP_FIN_LOAD,
		OP_FIN_LOOKUP,
		OP_B_CLR,
		OP_B_CNT_RD,
		OP_B_CNT_OFF,
		OP_B_CNT_WR,
		OP_B_PRE_RD,
		OP_B_PRE_WR,
		OP_B_SC_RD,
		OP_B_SC_CUR,
		OP_B_SC_WR,
		OP_B_MK_RD,
		OP_B_MK_END,
		OP_B_MS_RD,
		OP_B_MS_ACC,
		OP_B_DIV_GO,
		OP_B_MK_WR,
		OP_B_NEXT,
		OP_B_GDIV_GO,
		OP_FIN_BUILD,
		OP_E_RD0,
		OP_E_RD1,
		OP_E_RD2,
		OP_FIN_ENTRY,
		OP_M_RD,
		OP_FIN_MEAN
	} dp_op_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             pre_fail;
		logic             loop_end;
		logic             match;
		logic             side;
		logic             div_done;
	} dp_stat_t;

endpackage

@@ rtl/core/ratings_coo_to_csr_table.sv @@
// Ratings table top level: controller plus datapath.
// Depends on rct_pkg, rct_ctrl, rct_dpath (and rct_div below it).
//
// Usage: drive command and its operand fields with start high; the request is
// taken on a clock edge where start is high and busy is low. Exactly one
// result follows per request: done is high for one cycle with status and the
// data fields; user_total/item_total always show the current counts. The
// receiver cannot stall, so results must be taken in the done cycle.
// Build runs, per side, a clear of the offsets, a count pass, a prefix sum and
// a scatter pass over the ratings, then per key a slice sum and a mean divide;
// a global mean divide ends it. Lookups compare map entries one by one; load
// searches the user map, then the item map, and stores the triple if there is room.
// busy drops in the same cycle as done, so the next request can follow at once.
// Reset clears all counts and the built flag; memories need no clearing.
module ratings_coo_to_csr_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [rct_pkg::CMD_W-1:0]         command,
	input  logic signed [rct_pkg::ID_W-1:0]   user_ext_id,
	input  logic signed [rct_pkg::ID_W-1:0]   item_ext_id,
	input  logic [rct_pkg::RT_W-1:0]          rating_value,
	input  logic signed [rct_pkg::SLOT_W-1:0] slot_index,
	input  logic [rct_pkg::POS_W-1:0]         position,
	output logic                              done,
	output logic [rct_pkg::ST_W-1:0]          status,
	output logic signed [rct_pkg::SLOT_W-1:0] dense_index,
	output logic [rct_pkg::CNT_W-1:0]         slice_count,
	output logic [rct_pkg::EIDX_W-1:0]        entry_index,
	output logic [rct_pkg::RT_W-1:0]          entry_value,
	output logic [rct_pkg::RT_W-1:0]          mean_value,
	output logic [rct_pkg::TOT_W-1:0]         user_total,
	output logic [rct_pkg::TOT_W-1:0]         item_total
);
	import rct_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;

	rct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.op     (op)
	);

	rct_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.stat         (stat),
		.command      (command),
		.user_ext_id  (user_ext_id),
		.item_ext_id  (item_ext_id),
		.rating_value (rating_value),
		.slot_index   (slot_index),
		.position     (position),
		.done         (done),
		.status       (status),
		.dense_index  (dense_index),
		.slice_count  (slice_count),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.mean_value   (mean_value),
		.user_total   (user_total),
		.item_total   (item_total)
	);

endmodule

@@ rtl/core/rct_div.sv @@
// Mean divider: restoring division, one quotient bit per cycle, 8 bits.
// Depends on rct_pkg. Quotient is valid from the done pulse on.
module rct_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [rct_pkg::SUM_W-1:0] dividend,
	input  logic [rct_pkg::RC_W-1:0]  divisor,
	output logic [rct_pkg::RT_W-1:0]  quotient,
	output logic                     done
);
	import rct_pkg::*;

	localparam int TR_W = RC_W + RT_W;

	logic [SUM_W-1:0] rem_q;
	logic [RC_W-1:0]  div_q;
	logic [RT_W-1:0]  quo_q;
	logic [2:0]       step_q;
	logic             run_q;
	logic             done_q;
	logic [TR_W-1:0]  shifted;
	logic             ge;

	assign shifted = TR_W'(div_q) << step_q;
	assign ge = TR_W'(rem_q) >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 3'd7;
			end else if (run_q) begin
				step_q <= step_q - 3'd1;
				if (step_q == 3'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			div_q <= divisor;
			quo_q <= '0;
		end else if (run_q && ge) begin
			rem_q         <= rem_q - shifted[SUM_W-1:0];
			quo_q[step_q] <= 1'b1;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ rtl/core/rct_ctrl.sv @@
// Ratings table controller: sequences search, load, build and read steps.
// Depends on rct_pkg. Drives one datapath micro-op per cycle.
module rct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rct_pkg::dp_stat_t stat,
	output rct_pkg::dp_op_t   op
);
	import rct_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_SRCH, S_SCMP, S_SDONE,
		S_BCLR, S_BCNT, S_BCNT1, S_BCNT2, S_BPRE, S_BPRE1,
		S_BSC, S_BSC1, S_BSC2, S_BMK, S_BMK1, S_BMS, S_BMS1,
		S_BDIV, S_BDWAIT, S_BMKWR, S_BNEXT, S_BGDIV, S_BGWAIT, S_BFIN,
		S_ERD0, S_ERD1, S_ERD2, S_EFIN, S_MRD, S_MFIN
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		op      = OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op      = OP_CAPTURE;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.pre_fail) begin
					op      = OP_FIN_PRE;
					state_d = S_IDLE;
				end else begin
					case (stat.cmd)
						CMD_CLEAR: begin
							op      = OP_FIN_CLEAR;
							state_d = S_IDLE;
						end
						CMD_LOAD, CMD_ULOOK, CMD_ILOOK: state_d = S_SRCH;
						CMD_BUILD: state_d = S_BCLR;
						CMD_UENTRY, CMD_IENTRY: state_d = S_ERD0;
						CMD_UMEAN, CMD_IMEAN, CMD_GMEAN: state_d = S_MRD;
						default: begin
							op      = OP_FIN_PRE;
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SRCH: begin
				op      = OP_SRCH_RD;
				state_d = stat.loop_end ? S_SDONE : S_SCMP;
			end
			S_SCMP: begin
				op      = OP_SRCH_CMP;
				state_d = stat.match ? S_SDONE : S_SRCH;
			end
			S_SDONE: begin
				if (stat.cmd == CMD_LOAD && !stat.side) begin
					op      = OP_SAVE_U;
					state_d = S_SRCH;
				end else if (stat.cmd == CMD_LOAD) begin
					op      = OP_FIN_LOAD;
					state_d = S_IDLE;
				end else begin
					op      = OP_FIN_LOOKUP;
					state_d = S_IDLE;
				end
			end
			S_BCLR: begin
				op = OP_B_CLR;
				if (stat.loop_end) state_d = S_BCNT;
			end
			S_BCNT: begin
				op      = OP_B_CNT_RD;
				state_d = stat.loop_end ? S_BPRE : S_BCNT1;
			end
			S_BCNT1: begin
				op      = OP_B_CNT_OFF;
				state_d = S_BCNT2;
			end
			S_BCNT2: begin
				op      = OP_B_CNT_WR;
				state_d = S_BCNT;
			end
			S_BPRE: begin
				op      = OP_B_PRE_RD;
				state_d = stat.loop_end ? S_BSC : S_BPRE1;
			end
			S_BPRE1: begin
				op      = OP_B_PRE_WR;
				state_d = S_BPRE;
			end
			S_BSC: begin
				op      = OP_B_SC_RD;
				state_d = stat.loop_end ? S_BMK : S_BSC1;
			end
			S_BSC1: begin
				op      = OP_B_SC_CUR;
				state_d = S_BSC2;
			end
			S_BSC2: begin
				op      = OP_B_SC_WR;
				state_d = S_BSC;
			end
			S_BMK: begin
				op = OP_B_MK_RD;
				if (stat.loop_end) state_d = stat.side ? S_BGDIV : S_BNEXT;
				else state_d = S_BMK1;
			end
			S_BMK1: begin
				op      = OP_B_MK_END;
				state_d = S_BMS;
			end
			S_BMS: begin
				op      = OP_B_MS_RD;
				state_d = stat.loop_end ? S_BDIV : S_BMS1;
			end
			S_BMS1: begin
				op      = OP_B_MS_ACC;
				state_d = S_BMS;
			end
			S_BDIV: begin
				op      = OP_B_DIV_GO;
				state_d = S_BDWAIT;
			end
			S_BDWAIT: begin
				if (stat.div_done) state_d = S_BMKWR;
			end
			S_BMKWR: begin
				op      = OP_B_MK_WR;
				state_d = S_BMK;
			end
			S_BNEXT: begin
				op      = OP_B_NEXT;
				state_d = S_BCLR;
			end
			S_BGDIV: begin
				op      = OP_B_GDIV_GO;
				state_d = S_BGWAIT;
			end
			S_BGWAIT: begin
				if (stat.div_done) state_d = S_BFIN;
			end
			S_BFIN: begin
				op      = OP_FIN_BUILD;
				state_d = S_IDLE;
			end
			S_ERD0: begin
				op      = OP_E_RD0;
				state_d = S_ERD1;
			end
			S_ERD1: begin
				op      = OP_E_RD1;
				state_d = S_ERD2;
			end
			S_ERD2: begin
				op      = OP_E_RD2;
				state_d = S_EFIN;
			end
			S_EFIN: begin
				op      = OP_FIN_ENTRY;
				state_d = S_IDLE;
			end
			S_MRD: begin
				op      = OP_M_RD;
				state_d = S_MFIN;
			end
			S_MFIN: begin
				op      = OP_FIN_MEAN;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

@@ rtl/core/rct_dpath.sv @@
// Ratings table datapath: id maps, triple store, offset/cursor/entry/mean
// memories, counters and result registers. Depends on rct_pkg, rct_div.
module rct_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rct_pkg::dp_op_t                 op,
	output rct_pkg::dp_stat_t               stat,
	input  logic [rct_pkg::CMD_W-1:0]       command,
	input  logic signed [rct_pkg::ID_W-1:0] user_ext_id,
	input  logic signed [rct_pkg::ID_W-1:0] item_ext_id,
	input  logic [rct_pkg::RT_W-1:0]        rating_value,
	input  logic signed [rct_pkg::SLOT_W-1:0] slot_index,
	input  logic [rct_pkg::POS_W-1:0]       position,
	output logic                            done,
	output logic [rct_pkg::ST_W-1:0]        status,
	output logic signed [rct_pkg::SLOT_W-1:0] dense_index,
	output logic [rct_pkg::CNT_W-1:0]       slice_count,
	output logic [rct_pkg::EIDX_W-1:0]      entry_index,
	output logic [rct_pkg::RT_W-1:0]        entry_value,
	output logic [rct_pkg::RT_W-1:0]        mean_value,
	output logic [rct_pkg::TOT_W-1:0]       user_total,
	output logic [rct_pkg::TOT_W-1:0]       item_total
);
	import rct_pkg::*;

	// memories
	logic [ID_W-1:0]  umap_mem [MAX_USERS];
	logic [ID_W-1:0]  imap_mem [MAX_ITEMS];
	logic [RAW_W-1:0] raw_mem  [MAX_RATINGS];
	logic [RC_W-1:0]  uoff_mem [MAX_KEYS+1];
	logic [RC_W-1:0]  ioff_mem [MAX_KEYS+1];
	logic [RC_W-1:0]  cur_mem  [MAX_KEYS+1];
	logic [ENT_W-1:0] uent_mem [MAX_RATINGS];
	logic [ENT_W-1:0] ient_mem [MAX_RATINGS];
	logic [RT_W-1:0]  umean_mem [MAX_KEYS];
	logic [RT_W-1:0]  imean_mem [MAX_KEYS];

	logic [ID_W-1:0]  umap_rd, imap_rd;
	logic [RAW_W-1:0] raw_rd;
	logic [RC_W-1:0]  uoff_rd, ioff_rd, cur_rd;
	logic [ENT_W-1:0] uent_rd, ient_rd;
	logic [RT_W-1:0]  umean_rd, imean_rd;

	// request and state registers
	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   uid_q, iid_q;
	logic [RT_W-1:0]   rating_q;
	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  pos_q;
	logic [RC_W-1:0]   rc_q;
	logic [NK_W-1:0]   uc_q, ic_q;
	logic              built_q;
	logic [RT_W-1:0]   gmean_q;
	logic              side_q;
	logic [RC_W-1:0]   idx_q, p_q, start_q, end_q;
	logic [NK_W-1:0]   uk_q, key_q;
	logic [SUM_W-1:0]  acc_q, gsum_q;
	logic [ENT_W-1:0]  ent_d_q;

	// result registers
	logic              done_q;
	logic [ST_W-1:0]   status_q;
	logic [SLOT_W-1:0] dense_q;
	logic [CNT_W-1:0]  scount_q;
	logic [EIDX_W-1:0] eidx_q;
	logic [RT_W-1:0]   eval_q, mean_q;

	// views
	logic [ID_W-1:0]  map_rd, id_sel;
	logic [RC_W-1:0]  off_rd;
	logic [ENT_W-1:0] ent_rd;
	logic [RT_W-1:0]  mean_rd;
	logic [NK_W-1:0]  n_sel;
	logic [KA_W-1:0]  raw_key, raw_other;
	logic [RT_W-1:0]  raw_rating;
	logic [RC_W-1:0]  pre_sum, slice_len;
	logic [ST_W-1:0]  pre_status;
	logic             loop_end;
	logic             unew, inew, load_full, pos_bad;

	// memory port controls
	logic [KA_W-1:0]  map_ra, mean_ra, mean_wa;
	logic [RA_W-1:0]  raw_ra, ent_ra, ent_wa;
	logic [NK_W-1:0]  off_ra, off_wa, cur_ra, cur_wa;
	logic [RC_W-1:0]  off_wd, cur_wd;
	logic [RT_W-1:0]  mean_wd;
	logic             off_we, cur_we, ent_we, mean_we, umap_we, imap_we, raw_we;

	// divider
	logic             div_start, div_done;
	logic [SUM_W-1:0] div_num;
	logic [RC_W-1:0]  div_den;
	logic [RT_W-1:0]  div_quo;

	assign map_rd     = side_q ? imap_rd : umap_rd;
	assign id_sel     = side_q ? iid_q : uid_q;
	assign off_rd     = side_q ? ioff_rd : uoff_rd;
	assign ent_rd     = side_q ? ient_rd : uent_rd;
	assign mean_rd    = side_q ? imean_rd : umean_rd;
	assign n_sel      = side_q ? ic_q : uc_q;
	assign raw_key    = side_q ? raw_rd[RT_W +: KA_W] : raw_rd[RAW_W-1 -: KA_W];
	assign raw_other  = side_q ? raw_rd[RAW_W-1 -: KA_W] : raw_rd[RT_W +: KA_W];
	assign raw_rating = raw_rd[RT_W-1:0];
	assign pre_sum    = acc_q[RC_W-1:0] + off_rd;
	assign slice_len  = end_q - start_q;
	assign pos_bad    = RC_W'(pos_q) >= slice_len;
	assign unew       = (uk_q == uc_q);
	assign inew       = (idx_q == RC_W'(ic_q));
	assign load_full  = (unew && uc_q >= NK_W'(MAX_USERS)) ||
	                    (inew && ic_q >= NK_W'(MAX_ITEMS));

	always_comb begin
		pre_status = ST_OK;
		case (cmd_q)
			CMD_CLEAR, CMD_ULOOK, CMD_ILOOK: pre_status = ST_OK;
			CMD_LOAD: begin
				if (built_q) pre_status = ST_BUILT;
				else if (rc_q >= RC_W'(MAX_RATINGS)) pre_status = ST_FULL;
			end
			CMD_BUILD: begin
				if (built_q) pre_status = ST_BUILT;
			end
			CMD_UENTRY, CMD_IENTRY, CMD_UMEAN, CMD_IMEAN: begin
				if (!built_q) pre_status = ST_NOT_BUILT;
				else if (slot_q[SLOT_W-1] || NK_W'(slot_q) >= n_sel) pre_status = ST_RANGE;
			end
			CMD_GMEAN: begin
				if (!built_q) pre_status = ST_NOT_BUILT;
			end
			default: pre_status = ST_RANGE;
		endcase
	end

	always_comb begin
		loop_end = 1'b0;
		case (op)
			OP_SRCH_RD:              loop_end = (idx_q == RC_W'(n_sel));
			OP_B_CLR, OP_B_PRE_RD:   loop_end = (idx_q == RC_W'(n_sel) + RC_W'(1));
			OP_B_CNT_RD, OP_B_SC_RD: loop_end = (idx_q == rc_q);
			OP_B_MK_RD:              loop_end = (idx_q == RC_W'(n_sel));
			OP_B_MS_RD:              loop_end = (p_q == end_q);
			default:                 loop_end = 1'b0;
		endcase
	end

	assign stat.cmd      = cmd_q;
	assign stat.pre_fail = (pre_status != ST_OK);
	assign stat.loop_end = loop_end;
	assign stat.match    = (map_rd == id_sel);
	assign stat.side     = side_q;
	assign stat.div_done = div_done;

	always_comb begin
		map_ra  = idx_q[KA_W-1:0];
		raw_ra  = idx_q[RA_W-1:0];
		off_ra  = idx_q[NK_W-1:0];
		cur_ra  = NK_W'(raw_key);
		ent_ra  = p_q[RA_W-1:0];
		mean_ra = slot_q[KA_W-1:0];
		off_we  = 1'b0;
		off_wa  = idx_q[NK_W-1:0];
		off_wd  = '0;
		cur_we  = 1'b0;
		cur_wa  = idx_q[NK_W-1:0];
		cur_wd  = pre_sum;
		ent_we  = 1'b0;
		ent_wa  = cur_rd[RA_W-1:0];
		mean_we = 1'b0;
		mean_wa = idx_q[KA_W-1:0];
		mean_wd = (end_q == start_q) ? '0 : div_quo;
		umap_we = 1'b0;
		imap_we = 1'b0;
		raw_we  = 1'b0;
		case (op)
			OP_FIN_LOAD: begin
				umap_we = !load_full && unew;
				imap_we = !load_full && inew;
				raw_we  = !load_full;
			end
			OP_B_CLR:     off_we = !loop_end;
			OP_B_CNT_OFF: off_ra = NK_W'(raw_key) + NK_W'(1);
			OP_B_CNT_WR: begin
				off_we = 1'b1;
				off_wa = key_q;
				off_wd = off_rd + RC_W'(1);
			end
			OP_B_PRE_WR: begin
				off_we = 1'b1;
				off_wd = pre_sum;
				cur_we = 1'b1;
			end
			OP_B_SC_WR: begin
				ent_we = 1'b1;
				cur_we = 1'b1;
				cur_wa = key_q;
				cur_wd = cur_rd + RC_W'(1);
			end
			OP_B_MK_RD: off_ra = idx_q[NK_W-1:0] + NK_W'(1);
			OP_B_MK_WR: mean_we = 1'b1;
			OP_E_RD0:   off_ra = slot_q[NK_W-1:0];
			OP_E_RD1:   off_ra = slot_q[NK_W-1:0] + NK_W'(1);
			OP_E_RD2:   ent_ra = start_q[RA_W-1:0] + RA_W'(pos_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (umap_we) umap_mem[uc_q[KA_W-1:0]] <= uid_q;
		umap_rd <= umap_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (imap_we) imap_mem[ic_q[KA_W-1:0]] <= iid_q;
		imap_rd <= imap_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (raw_we) raw_mem[rc_q[RA_W-1:0]] <= {uk_q[KA_W-1:0], idx_q[KA_W-1:0], rating_q};
		raw_rd <= raw_mem[raw_ra];
	end

	always_ff @(posedge clk) begin
		if (off_we && !side_q) uoff_mem[off_wa] <= off_wd;
		uoff_rd <= uoff_mem[off_ra];
	end

	always_ff @(posedge clk) begin
		if (off_we && side_q) ioff_mem[off_wa] <= off_wd;
		ioff_rd <= ioff_mem[off_ra];
	end

	always_ff @(posedge clk) begin
		if (cur_we) cur_mem[cur_wa] <= cur_wd;
		cur_rd <= cur_mem[cur_ra];
	end

	always_ff @(posedge clk) begin
		if (ent_we && !side_q) uent_mem[ent_wa] <= ent_d_q;
		uent_rd <= uent_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (ent_we && side_q) ient_mem[ent_wa] <= ent_d_q;
		ient_rd <= ient_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (mean_we && !side_q) umean_mem[mean_wa] <= mean_wd;
		umean_rd <= umean_mem[mean_ra];
	end

	always_ff @(posedge clk) begin
		if (mean_we && side_q) imean_mem[mean_wa] <= mean_wd;
		imean_rd <= imean_mem[mean_ra];
	end

	assign div_start = (op == OP_B_DIV_GO) || (op == OP_B_GDIV_GO);
	assign div_num   = (op == OP_B_GDIV_GO) ? gsum_q : acc_q;
	assign div_den   = (op == OP_B_GDIV_GO) ? rc_q : slice_len;

	rct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q    <= '0;
			uc_q    <= '0;
			ic_q    <= '0;
			built_q <= 1'b0;
			gmean_q <= '0;
			done_q  <= 1'b0;
			side_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (op)
				OP_CAPTURE: begin
					idx_q  <= '0;
					side_q <= (command == CMD_ILOOK) || (command == CMD_IENTRY) ||
					          (command == CMD_IMEAN);
				end
				OP_SRCH_CMP: begin
					if (!stat.match) idx_q <= idx_q + RC_W'(1);
				end
				OP_SAVE_U: begin
					idx_q  <= '0;
					side_q <= 1'b1;
				end
				OP_FIN_PRE, OP_FIN_LOOKUP, OP_FIN_ENTRY, OP_FIN_MEAN: done_q <= 1'b1;
				OP_FIN_CLEAR: begin
					done_q  <= 1'b1;
					rc_q    <= '0;
					uc_q    <= '0;
					ic_q    <= '0;
					built_q <= 1'b0;
					gmean_q <= '0;
				end
				OP_FIN_LOAD: begin
					done_q <= 1'b1;
					if (!load_full) begin
						rc_q <= rc_q + RC_W'(1);
						if (unew) uc_q <= uc_q + NK_W'(1);
						if (inew) ic_q <= ic_q + NK_W'(1);
					end
				end
				OP_B_CLR, OP_B_CNT_RD, OP_B_PRE_RD, OP_B_SC_RD, OP_B_MK_RD: begin
					if (loop_end) idx_q <= '0;
					else if (op == OP_B_CLR) idx_q <= idx_q + RC_W'(1);
				end
				OP_B_CNT_WR, OP_B_PRE_WR, OP_B_SC_WR, OP_B_MK_WR: idx_q <= idx_q + RC_W'(1);
				OP_B_NEXT: begin
					idx_q  <= '0;
					side_q <= 1'b1;
				end
				OP_FIN_BUILD: begin
					done_q  <= 1'b1;
					built_q <= 1'b1;
					gmean_q <= (rc_q == '0) ? '0 : div_quo;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: begin
				cmd_q    <= command;
				uid_q    <= user_ext_id;
				iid_q    <= item_ext_id;
				rating_q <= rating_value;
				slot_q   <= slot_index;
				pos_q    <= position;
				acc_q    <= '0;
				gsum_q   <= '0;
				start_q  <= '0;
			end
			OP_SAVE_U: uk_q <= idx_q[NK_W-1:0];
			OP_B_CLR, OP_B_CNT_RD, OP_B_PRE_RD, OP_B_SC_RD, OP_B_MK_RD: begin
				if (loop_end) acc_q <= '0;
			end
			OP_B_CNT_OFF: begin
				key_q <= NK_W'(raw_key) + NK_W'(1);
				if (!side_q) gsum_q <= gsum_q + SUM_W'(raw_rating);
			end
			OP_B_PRE_WR: acc_q <= SUM_W'(pre_sum);
			OP_B_SC_CUR: begin
				key_q   <= NK_W'(raw_key);
				ent_d_q <= {raw_other, raw_rating};
			end
			OP_B_MK_END: begin
				end_q <= off_rd;
				p_q   <= start_q;
				acc_q <= '0;
			end
			OP_B_MS_ACC: begin
				acc_q <= acc_q + SUM_W'(ent_rd[RT_W-1:0]);
				p_q   <= p_q + RC_W'(1);
			end
			OP_B_MK_WR: start_q <= end_q;
			OP_B_NEXT: begin
				acc_q   <= '0;
				start_q <= '0;
			end
			OP_E_RD1: start_q <= off_rd;
			OP_E_RD2: end_q <= off_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_FIN_PRE, OP_FIN_CLEAR, OP_FIN_BUILD: begin
				status_q <= (op == OP_FIN_PRE) ? pre_status : ST_OK;
				dense_q  <= '0;
				scount_q <= '0;
				eidx_q   <= '0;
				eval_q   <= '0;
				mean_q   <= '0;
			end
			OP_FIN_LOAD: begin
				status_q <= load_full ? ST_FULL : ST_OK;
				dense_q  <= '0;
				scount_q <= '0;
				eidx_q   <= '0;
				eval_q   <= '0;
				mean_q   <= '0;
			end
			OP_FIN_LOOKUP: begin
				status_q <= (idx_q == RC_W'(n_sel)) ? ST_NOT_FOUND : ST_OK;
				dense_q  <= (idx_q == RC_W'(n_sel)) ? '1 : SLOT_W'(idx_q);
				scount_q <= '0;
				eidx_q   <= '0;
				eval_q   <= '0;
				mean_q   <= '0;
			end
			OP_FIN_ENTRY: begin
				status_q <= pos_bad ? ST_RANGE : ST_OK;
				dense_q  <= '0;
				scount_q <= CNT_W'(slice_len);
				eidx_q   <= pos_bad ? '0 : EIDX_W'(ent_rd[ENT_W-1 -: KA_W]);
				eval_q   <= pos_bad ? '0 : ent_rd[RT_W-1:0];
				mean_q   <= '0;
			end
			OP_FIN_MEAN: begin
				status_q <= ST_OK;
				dense_q  <= '0;
				scount_q <= '0;
				eidx_q   <= '0;
				eval_q   <= '0;
				mean_q   <= (cmd_q == CMD_GMEAN) ? gmean_q : mean_rd;
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign status      = status_q;
	assign dense_index = $signed(dense_q);
	assign slice_count = scount_q;
	assign entry_index = eidx_q;
	assign entry_value = eval_q;
	assign mean_value  = mean_q;
	assign user_total  = TOT_W'(uc_q);
	assign item_total  = TOT_W'(ic_q);

endmodule

@@ rtl/core/rct_chk.sv @@
// Port-level checks for the ratings table, bound to the top level.
// Depends on rct_pkg.
module rct_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [rct_pkg::ST_W-1:0]          status,
	input logic signed [rct_pkg::SLOT_W-1:0] dense_index
);
	import rct_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request not taken");

	a_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_notfound: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NOT_FOUND |-> dense_index == -11'sd1)
		else $error("unknown id without -1 index");

endmodule

bind ratings_coo_to_csr_table rct_chk u_chk (.*);

@@ tb/sv/ratings_coo_to_csr_table_tb.sv @@
// Testbench for ratings_coo_to_csr_table: directed and random command streams
// checked against an in-bench model of the ratings table. Depends on rct_pkg.
`timescale 1ns / 100ps

module ratings_coo_to_csr_table_tb;
	import rct_pkg::*;

	typedef struct {
		logic [2:0]  status;
		logic [10:0] dense;
		logic [12:0] scount;
		logic [9:0]  eidx;
		logic [7:0]  eval;
		logic [7:0]  mean;
		logic [10:0] utot;
		logic [10:0] itot;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [3:0]  command = '0;
	logic [31:0] user_ext_id = '0;
	logic [31:0] item_ext_id = '0;
	logic [7:0]  rating_value = '0;
	logic [10:0] slot_index = '0;
	logic [11:0] position = '0;
	logic        busy, done;
	logic [2:0]  status;
	logic [10:0] dense_index;
	logic [12:0] slice_count;
	logic [9:0]  entry_index;
	logic [7:0]  entry_value, mean_value;
	logic [10:0] user_total, item_total;

	ratings_coo_to_csr_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.user_ext_id(user_ext_id), .item_ext_id(item_ext_id), .rating_value(rating_value),
		.slot_index(slot_index), .position(position), .done(done), .status(status),
		.dense_index(dense_index), .slice_count(slice_count), .entry_index(entry_index),
		.entry_value(entry_value), .mean_value(mean_value), .user_total(user_total),
		.item_total(item_total)
	);

	always #5 clk = ~clk;

	// table model state
	logic [31:0] user_map [MAX_USERS];
	logic [31:0] item_map [MAX_ITEMS];
	int trip_user [MAX_RATINGS];
	int trip_item [MAX_RATINGS];
	int trip_rate [MAX_RATINGS];
	int user_off [MAX_USERS+1];
	int item_off [MAX_ITEMS+1];
	int user_ent_idx [MAX_RATINGS];
	int user_ent_rt [MAX_RATINGS];
	int item_ent_idx [MAX_RATINGS];
	int item_ent_rt [MAX_RATINGS];
	int user_avg [MAX_USERS];
	int item_avg [MAX_ITEMS];
	int cursor [MAX_KEYS+1];
	int global_avg, n_ratings, n_users, n_items;
	bit is_built;

	result_t pending_results[$];
	bit      failed = 1'b0;
	bit      steady = 1'b0;
	int      n_sent = 0;
	logic [31:0] id_pool [16];

	function automatic int find_key(bit by_user, logic [31:0] id);
		int n;
		n = by_user ? n_users : n_items;
		for (int k = 0; k < n; k++)
			if ((by_user ? user_map[k] : item_map[k]) == id)
				return k;
		return n;
	endfunction

	task automatic build_side(bit by_user);
		int nk, key, p, sum, first, last;
		nk = by_user ? n_users : n_items;
		for (int k = 0; k <= nk; k++)
			if (by_user) user_off[k] = 0; else item_off[k] = 0;
		for (int r = 0; r < n_ratings; r++) begin
			key = by_user ? trip_user[r] : trip_item[r];
			if (by_user) user_off[key+1]++; else item_off[key+1]++;
		end
		for (int k = 1; k <= nk; k++)
			if (by_user) user_off[k] += user_off[k-1]; else item_off[k] += item_off[k-1];
		for (int k = 0; k <= nk; k++)
			cursor[k] = by_user ? user_off[k] : item_off[k];
		for (int r = 0; r < n_ratings; r++) begin
			key = by_user ? trip_user[r] : trip_item[r];
			p = cursor[key];
			cursor[key] = cursor[key] + 1;
			if (by_user) begin
				user_ent_idx[p] = trip_item[r];
				user_ent_rt[p] = trip_rate[r];
			end else begin
				item_ent_idx[p] = trip_user[r];
				item_ent_rt[p] = trip_rate[r];
			end
		end
		for (int k = 0; k < nk; k++) begin
			first = by_user ? user_off[k] : item_off[k];
			last = by_user ? user_off[k+1] : item_off[k+1];
			sum = 0;
			for (int q = first; q < last; q++)
				sum += by_user ? user_ent_rt[q] : item_ent_rt[q];
			if (by_user) user_avg[k] = (first == last) ? 0 : (sum / (last - first)) & 255;
			else item_avg[k] = (first == last) ? 0 : (sum / (last - first)) & 255;
		end
	endtask

	task automatic predict_table(input logic [3:0] cmd, input logic [31:0] uid,
			input logic [31:0] iid, input logic [7:0] rt, input logic [10:0] slot,
			input logic [11:0] pos, output result_t res);
		int u, i, n, first, sum;
		bit by_user;
		res = '{default: '0};
		case (cmd)
			CMD_CLEAR: begin
				n_ratings = 0; n_users = 0; n_items = 0; global_avg = 0; is_built = 0;
			end
			CMD_LOAD: begin
				if (is_built) res.status = ST_BUILT;
				else if (n_ratings >= MAX_RATINGS) res.status = ST_FULL;
				else begin
					u = find_key(1, uid);
					i = find_key(0, iid);
					if ((u == n_users && n_users >= MAX_USERS) ||
							(i == n_items && n_items >= MAX_ITEMS))
						res.status = ST_FULL;
					else begin
						if (u == n_users) begin
							user_map[n_users] = uid;
							n_users = n_users + 1;
						end
						if (i == n_items) begin
							item_map[n_items] = iid;
							n_items = n_items + 1;
						end
						trip_user[n_ratings] = u;
						trip_item[n_ratings] = i;
						trip_rate[n_ratings] = int'(rt);
						n_ratings++;
					end
				end
			end
			CMD_BUILD: begin
				if (is_built) res.status = ST_BUILT;
				else begin
					build_side(1);
					build_side(0);
					sum = 0;
					for (int r = 0; r < n_ratings; r++) sum += trip_rate[r];
					global_avg = n_ratings ? (sum / n_ratings) & 255 : 0;
					is_built = 1;
				end
			end
			CMD_ULOOK, CMD_ILOOK: begin
				by_user = (cmd == CMD_ULOOK);
				n = by_user ? n_users : n_items;
				u = find_key(by_user, by_user ? uid : iid);
				if (u == n) begin
					res.status = ST_NOT_FOUND;
					res.dense = '1;
				end else res.dense = 11'(u);
			end
			CMD_UENTRY, CMD_IENTRY, CMD_UMEAN, CMD_IMEAN: begin
				by_user = (cmd == CMD_UENTRY || cmd == CMD_UMEAN);
				n = by_user ? n_users : n_items;
				if (!is_built) res.status = ST_NOT_BUILT;
				else if (slot[10] || slot >= n) res.status = ST_RANGE;
				else if (cmd == CMD_UMEAN || cmd == CMD_IMEAN)
					res.mean = 8'(by_user ? user_avg[slot] : item_avg[slot]);
				else begin
					first = by_user ? user_off[slot] : item_off[slot];
					res.scount = 13'((by_user ? user_off[slot+1] : item_off[slot+1]) - first);
					if (pos >= res.scount) res.status = ST_RANGE;
					else begin
						res.eidx = 10'(by_user ? user_ent_idx[first+pos] :
							item_ent_idx[first+pos]);
						res.eval = 8'(by_user ? user_ent_rt[first+pos] :
							item_ent_rt[first+pos]);
					end
				end
			end
			CMD_GMEAN: begin
				if (!is_built) res.status = ST_NOT_BUILT;
				else res.mean = 8'(global_avg);
			end
			default: res.status = ST_RANGE;
		endcase
		res.utot = 11'(n_users);
		res.itot = 11'(n_items);
	endtask

	task automatic send_request(input logic [3:0] cmd, input logic [31:0] uid = 0,
			input logic [31:0] iid = 0, input logic [7:0] rt = 0,
			input logic [10:0] slot = 0, input logic [11:0] pos = 0);
		result_t res;
		bit was_busy;
		if (!steady && $urandom_range(0, 99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		user_ext_id <= uid;
		item_ext_id <= iid;
		rating_value <= rt;
		slot_index <= slot;
		position <= pos;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		predict_table(cmd, uid, iid, rt, slot, pos, res);
		pending_results = {pending_results, res};
		n_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(negedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, status);
				check_field("dense_index", want.dense, dense_index);
				check_field("slice_count", want.scount, slice_count);
				check_field("entry_index", want.eidx, entry_index);
				check_field("entry_value", want.eval, entry_value);
				check_field("mean_value", want.mean, mean_value);
				check_field("user_total", want.utot, user_total);
				check_field("item_total", want.itot, item_total);
			end
		end
	end

	function automatic logic [31:0] pick_id();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return id_pool[$urandom_range(0, 15)];
	endfunction

	task automatic test_unbuilt();
		send_request(CMD_UENTRY);
		send_request(CMD_IMEAN);
		send_request(CMD_GMEAN);
		send_request(CMD_ULOOK, 32'h8000_0000);
		send_request(CMD_ILOOK, 0, 32'h7FFF_FFFF);
		send_request(4'd10);
		send_request(4'd15);
		send_request(CMD_BUILD);
		send_request(CMD_GMEAN);
		send_request(CMD_UMEAN, 0, 0, 0, 11'd0);
		send_request(CMD_CLEAR);
	endtask

	task automatic test_basic();
		send_request(CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 8'hFF);
		send_request(CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00);
		send_request(CMD_LOAD, 32'h8000_0000, 32'hFFFF_FFFF, 8'h13);
		send_request(CMD_LOAD, 32'h0, 32'h8000_0000, 8'h80);
		send_request(CMD_ULOOK, 32'h7FFF_FFFF);
		send_request(CMD_ILOOK, 0, 32'h8000_0000);
		send_request(CMD_UENTRY, 0, 0, 0, 11'd0);
		send_request(CMD_BUILD);
		send_request(CMD_BUILD);
		send_request(CMD_LOAD, 32'h5, 32'h6, 8'h10);
		send_request(CMD_UENTRY, 0, 0, 0, 11'd0, 12'd1);
		send_request(CMD_IENTRY, 0, 0, 0, 11'd0, 12'd1);
		send_request(CMD_IENTRY, 0, 0, 0, 11'd2, 12'd0);
		send_request(CMD_UENTRY, 0, 0, 0, 11'd1, 12'd4095);
		send_request(CMD_UENTRY, 0, 0, 0, 11'h400);
		send_request(CMD_IMEAN, 0, 0, 0, 11'h7FF);
		send_request(CMD_IMEAN, 0, 0, 0, 11'd3);
		send_request(CMD_UMEAN, 0, 0, 0, 11'd0);
		send_request(CMD_UMEAN, 0, 0, 0, 11'd1023);
		send_request(CMD_GMEAN);
		send_request(CMD_CLEAR);
	endtask

	task automatic test_rating_full();
		steady = 1'b1;
		for (int r = 0; r < MAX_RATINGS; r++)
			send_request(CMD_LOAD, 32'd7, 32'd9, 8'($urandom));
		send_request(CMD_LOAD, 32'd7, 32'd9, 8'h55);
		send_request(CMD_LOAD, 32'd8, 32'd10, 8'h55);
		send_request(CMD_BUILD);
		steady = 1'b0;
		send_request(CMD_UENTRY, 0, 0, 0, 11'd0, 12'd4095);
		send_request(CMD_IENTRY, 0, 0, 0, 11'd0, 12'd0);
		send_request(CMD_UMEAN, 0, 0, 0, 11'd0);
		send_request(CMD_GMEAN);
		send_request(CMD_CLEAR);
	endtask

	task automatic test_keys_full();
		steady = 1'b1;
		for (int k = 0; k < MAX_USERS; k++)
			send_request(CMD_LOAD, 32'h1000 + k, ~(32'h1000 + k), 8'($urandom));
		steady = 1'b0;
		send_request(CMD_LOAD, 32'hABCD, ~32'h1000, 8'h11);
		send_request(CMD_LOAD, 32'h1000, 32'hABCD, 8'h11);
		send_request(CMD_LOAD, 32'h1003, ~32'h1005, 8'h22);
		send_request(CMD_ULOOK, 32'h1000 + 1023);
		send_request(CMD_BUILD);
		send_request(CMD_UENTRY, 0, 0, 0, 11'd1023, 12'd0);
		send_request(CMD_IENTRY, 0, 0, 0, 11'd1023, 12'd0);
		send_request(CMD_IMEAN, 0, 0, 0, 11'd1023);
		send_request(CMD_UMEAN, 0, 0, 0, 11'd3);
		send_request(CMD_CLEAR);
	endtask

	task automatic test_random();
		int stop_at, n_load, n_read, op;
		logic [10:0] slot;
		logic [11:0] pos;
		stop_at = n_sent + 450;
		while (n_sent < stop_at) begin
			steady = ($urandom_range(0, 5) == 0);
			n_load = $urandom_range(0, 8) == 0 ? $urandom_range(0, 3) : $urandom_range(5, 40);
			for (int j = 0; j < n_load; j++) begin
				if ($urandom_range(0, 9) == 0)
					send_request(4'($urandom_range(3, 15)), pick_id(), pick_id(),
						8'($urandom), 11'($urandom), 12'($urandom));
				else
					send_request(CMD_LOAD, pick_id(), pick_id(), 8'($urandom));
			end
			if ($urandom_range(0, 3) == 0) drain_results();
			send_request(CMD_BUILD);
			n_read = $urandom_range(10, 40);
			for (int j = 0; j < n_read; j++) begin
				op = $urandom_range(1, 15);
				slot = $urandom_range(0, 7) == 0 ? 11'($urandom) :
					11'($urandom_range(0, (n_users > n_items ? n_users : n_items) + 1));
				pos = $urandom_range(0, 7) == 0 ? 12'($urandom) : 12'($urandom_range(0, 6));
				send_request(4'(op), pick_id(), pick_id(), 8'($urandom), slot, pos);
			end
			send_request(CMD_CLEAR);
		end
	endtask

	initial begin
		id_pool[0] = 32'h8000_0000;
		id_pool[1] = 32'h7FFF_FFFF;
		id_pool[2] = 32'h0;
		id_pool[3] = 32'hFFFF_FFFF;
		for (int k = 4; k < 16; k++) id_pool[k] = $urandom;
		n_ratings = 0; n_users = 0; n_items = 0; global_avg = 0; is_built = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unbuilt();
		test_basic();
		test_rating_full();
		drain_results();
		test_keys_full();
		test_random();
		drain_results();
		repeat (40) @(posedge clk);
		if (!failed && pending_results.size() == 0)
			$display("ratings_coo_to_csr_table test passed");
		else
			$display("ratings_coo_to_csr_table test failed");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("ratings_coo_to_csr_table test failed");
		$finish;
	end

endmodule
